// File: sv/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// shared types and constants for the intel hex record parser
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int LIMIT_W = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd32768;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_COLON,
        CLS_HEX,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  nibble;
        logic [7:0]  code;
    } char_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        KIND_WRITE,
        KIND_REC_OK,
        KIND_CSUM_ERR,
        KIND_BAD_START,
        KIND_BAD_HEX,
        KIND_WRITE_LIMIT
    } result_kind_t;

endpackage

// File: sv/ihex_classifier.sv
// ----------------------------------------------------------------------------
// ihex_classifier
// sorts an incoming character into whitespace, colon, hex digit or other
// ----------------------------------------------------------------------------
module ihex_classifier (
    input  logic [7:0]          code,
    output ihex_pkg::char_item_t item
);

    always_comb
    begin
        item.code   = code;
        item.nibble = 4'h0;
        item.cls    = ihex_pkg::CLS_OTHER;
        if (code inside {8'h20, [8'h09:8'h0D]})
        begin
            item.cls = ihex_pkg::CLS_SPACE;
        end
        else if (code == ihex_pkg::CHAR_COLON)
        begin
            item.cls = ihex_pkg::CLS_COLON;
        end
        else if (code inside {[8'h30:8'h39]})
        begin
            item.cls    = ihex_pkg::CLS_HEX;
            item.nibble = code[3:0];
        end
        else if (code inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            // upper and lower case letters share the low bits
            item.cls    = ihex_pkg::CLS_HEX;
            item.nibble = code[3:0] + 4'd9;
        end
    end

endmodule

// File: sv/ihex_queue.sv
// ----------------------------------------------------------------------------
// ihex_queue
// short queue of classified characters between front and back
// ----------------------------------------------------------------------------
module ihex_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ihex_pkg::char_item_t    push_item,
    input  logic                    pop,
    output ihex_pkg::char_item_t    head_item,
    output ihex_pkg::queue_status_t status
);

    ihex_pkg::char_item_t entry_reg [ihex_pkg::QDEPTH];
    logic [ihex_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ihex_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ihex_pkg::QCNT_W-1:0] count_reg, count_next;

    localparam logic [ihex_pkg::QPTR_W-1:0] PTR_LAST = ihex_pkg::QPTR_W'(ihex_pkg::QDEPTH - 1);
    localparam logic [ihex_pkg::QCNT_W-1:0] CNT_FULL = ihex_pkg::QCNT_W'(ihex_pkg::QDEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_FULL);

endmodule

// File: sv/ihex_decoder.sv
// ----------------------------------------------------------------------------
// ihex_decoder
// record state machine, running sum and registered result stage
// ----------------------------------------------------------------------------
module ihex_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ihex_pkg::LIMIT_W-1:0]  image_limit,
    input  ihex_pkg::queue_status_t       q_status,
    input  ihex_pkg::char_item_t          item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ihex_pkg::result_kind_t        out_kind,
    output logic [15:0]                   out_address,
    output logic [7:0]                    out_value
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_TYPE,
        PH_DATA,
        PH_CSUM,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        low_next_reg, low_next_next;
    logic [3:0]  high_reg, high_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  index_reg, index_next;
    logic [15:0] base_reg, base_next;
    logic [7:0]  sum_reg, sum_next;

    logic                   out_valid_reg, out_valid_next;
    ihex_pkg::result_kind_t out_kind_reg, out_kind_next;
    logic [15:0]            out_address_reg, out_address_next;
    logic [7:0]             out_value_reg, out_value_next;

    logic [7:0]  byte_val;
    logic [7:0]  sum_add;
    logic [7:0]  index_inc;
    logic [15:0] write_addr;

    assign pop        = q_status.valid && (!out_valid_reg || out_ready);
    assign byte_val   = {high_reg, item.nibble};
    assign sum_add    = sum_reg + byte_val;
    assign index_inc  = index_reg + 8'd1;
    assign write_addr = base_reg + {8'h00, index_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        low_next_next    = low_next_reg;
        high_next        = high_reg;
        count_next       = count_reg;
        index_next       = index_reg;
        base_next        = base_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_kind_next    = out_kind_reg;
        out_address_next = out_address_reg;
        out_value_next   = out_value_reg;

        if (pop)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (item.cls == ihex_pkg::CLS_COLON)
                    begin
                        phase_next    = PH_COUNT;
                        low_next_next = 1'b0;
                        sum_next      = 8'h00;
                        index_next    = 8'h00;
                    end
                    else if (item.cls != ihex_pkg::CLS_SPACE)
                    begin
                        phase_next       = PH_SKIP;
                        out_valid_next   = 1'b1;
                        out_kind_next    = ihex_pkg::KIND_BAD_START;
                        out_address_next = 16'h0000;
                        out_value_next   = item.code;
                    end
                end
                PH_SKIP:
                begin
                    if (item.cls == ihex_pkg::CLS_SPACE)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                default:
                begin
                    if (item.cls != ihex_pkg::CLS_HEX)
                    begin
                        // whitespace truncates the record, anything else skips to whitespace; both report a bad digit
                        phase_next       = (item.cls == ihex_pkg::CLS_SPACE) ? PH_WAIT : PH_SKIP;
                        low_next_next    = 1'b0;
                        out_valid_next   = 1'b1;
                        out_kind_next    = ihex_pkg::KIND_BAD_HEX;
                        out_address_next = 16'h0000;
                        out_value_next   = item.code;
                    end
                    else if (!low_next_reg)
                    begin
                        high_next     = item.nibble;
                        low_next_next = 1'b1;
                    end
                    else
                    begin
                        low_next_next = 1'b0;
                        sum_next      = sum_add;
                        case (phase_reg)
                            PH_COUNT:
                            begin
                                count_next = byte_val;
                                phase_next = PH_ADDR_HI;
                            end
                            PH_ADDR_HI:
                            begin
                                base_next  = {byte_val, 8'h00};
                                phase_next = PH_ADDR_LO;
                            end
                            PH_ADDR_LO:
                            begin
                                base_next  = {base_reg[15:8], byte_val};
                                phase_next = PH_TYPE;
                            end
                            PH_TYPE:
                            begin
                                phase_next = (count_reg == 8'h00) ? PH_CSUM : PH_DATA;
                            end
                            PH_DATA:
                            begin
                                index_next = index_inc;
                                if (index_inc == count_reg)
                                begin
                                    phase_next = PH_CSUM;
                                end
                                out_valid_next   = 1'b1;
                                out_address_next = write_addr;
                                out_value_next   = byte_val;
                                if ({1'b0, write_addr} >= image_limit)
                                begin
                                    out_kind_next = ihex_pkg::KIND_WRITE_LIMIT;
                                end
                                else
                                begin
                                    out_kind_next = ihex_pkg::KIND_WRITE;
                                end
                            end
                            default:
                            begin
                                phase_next       = PH_SKIP;
                                out_valid_next   = 1'b1;
                                out_address_next = base_reg;
                                out_value_next   = sum_add;
                                out_kind_next    = (sum_add == 8'h00) ? ihex_pkg::KIND_REC_OK
                                                                      : ihex_pkg::KIND_CSUM_ERR;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            low_next_reg    <= 1'b0;
            high_reg        <= 4'h0;
            count_reg       <= 8'h00;
            index_reg       <= 8'h00;
            base_reg        <= 16'h0000;
            sum_reg         <= 8'h00;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= ihex_pkg::KIND_WRITE;
            out_address_reg <= 16'h0000;
            out_value_reg   <= 8'h00;
        end
        else
        begin
            phase_reg       <= phase_next;
            low_next_reg    <= low_next_next;
            high_reg        <= high_next;
            count_reg       <= count_next;
            index_reg       <= index_next;
            base_reg        <= base_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_address_reg <= out_address_next;
            out_value_reg   <= out_value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_address = out_address_reg;
    assign out_value   = out_value_reg;

endmodule

// File: sv/intel_hex_record_parser_core.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser_core
// decodes an intel hex character stream into byte writes and record status
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_ready     char_code
//   output    out        out_valid / out_ready   kind, address, value
//   config    in         cfg_we                  cfg_wdata (image limit)
//
// one character per cycle while the queue has room; a taken character is classified
// into the queue, then decoded into the output register, from which its result is offered
// the two-entry queue lets input take up to two characters while a result waits
// reset clears the parser state, queue and output register; limit is 32768
// ----------------------------------------------------------------------------
module intel_hex_record_parser_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   char_code,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   kind,
    output logic [15:0]                  address,
    output logic [7:0]                   value,
    input  logic                         cfg_we,
    input  logic [ihex_pkg::LIMIT_W-1:0] cfg_wdata
);

    logic [ihex_pkg::LIMIT_W-1:0] image_limit_reg;
    ihex_pkg::char_item_t         class_item;
    ihex_pkg::char_item_t         head_item;
    ihex_pkg::queue_status_t      q_status;
    ihex_pkg::result_kind_t       out_kind;
    logic                         push;
    logic                         pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_limit_reg <= ihex_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            image_limit_reg <= cfg_wdata;
        end
    end

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    ihex_classifier u_classifier (
        .code (char_code),
        .item (class_item)
    );

    ihex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (class_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    ihex_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_limit (image_limit_reg),
        .q_status    (q_status),
        .item        (head_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_kind    (out_kind),
        .out_address (address),
        .out_value   (value)
    );

    assign kind = out_kind;

    // accepted characters are held in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_status.valid)
    else $error("queue empty after a character transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == ihex_pkg::KIND_WRITE)) |-> ({1'b0, address} < image_limit_reg))
    else $error("data write reported at or above the image limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_kind == ihex_pkg::KIND_WRITE_LIMIT))
            |-> ({1'b0, address} >= image_limit_reg))
    else $error("limit flag raised below the image limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_kind == ihex_pkg::KIND_BAD_START)
                       || (out_kind == ihex_pkg::KIND_BAD_HEX))) |-> (address == 16'h0000))
    else $error("error transaction carries a non-zero address");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
    else $error("decoder popped an empty queue");

endmodule
